// ===== hw/rtl/pfla_pkg.sv =====
// Package for the page free-list allocator.
// Holds command, status and state codes and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package pfla_pkg;

  // Default sizing for the top-level parameters
  localparam int unsigned MAX_PAGES_DEF  = 256;
  localparam int unsigned PAGE_BYTES_DEF = 4096;

  // Fixed field widths
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_END   = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_INIT  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_REJECT = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_FREE,
    S_INIT_SETUP,
    S_INIT_RUN
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;     // latch transaction payload, read table at head
    logic alloc_fin;   // pop head, load result
    logic free_fin;    // check address, push if good, load result
    logic init_setup;  // empty the list, compute page count
    logic init_push;   // push next page of the init sweep
    logic res_ok;      // load a plain ok result
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic init_last;   // every page of the init sweep is pushed
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pfla_dp.sv =====
// Datapath of the page free-list allocator: config registers, head register,
// next-index table memory, address checks and result registers. Uses pfla_pkg.
`default_nettype none

module pfla_dp
  import pfla_pkg::*;
#(
  parameter int unsigned MAX_PAGES  = MAX_PAGES_DEF,
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [ADDR_W-1:0]    cfg_wdata_i,
  input  wire logic [ADDR_W-1:0]    page_address_i,
  input  wire dp_cmd_t              cmd_i,
  output dp_stat_t                  stat_o,
  output logic [ADDR_W-1:0]         granted_address_o,
  output logic [STAT_W-1:0]         status_o
);

  localparam int unsigned IDXW     = $clog2(MAX_PAGES + 1);
  localparam int unsigned MW       = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned PAGE_LOG = $clog2(PAGE_BYTES);
  localparam int unsigned WW       = ADDR_W + 1;
  localparam logic [IDXW-1:0] NULL_IDX   = IDXW'(MAX_PAGES);
  localparam logic [WW-1:0]   PAGES_W    = WW'(MAX_PAGES);
  localparam logic [WW-1:0]   PAGE_MASK  = ~(WW'(PAGE_BYTES) - WW'(1));

  // Config registers; the rounded base is computed as heap_start is written
  logic [ADDR_W-1:0] heap_start_q, heap_end_q;
  logic [WW-1:0]     base_q, base_d;

  assign base_d = ({1'b0, cfg_wdata_i} + WW'(PAGE_BYTES - 1)) & PAGE_MASK;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_start_q <= '0;
      heap_end_q   <= '0;
      base_q       <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_HEAP_START) begin
        heap_start_q <= cfg_wdata_i;
        base_q       <= base_d;
      end else if (cfg_idx_i == CFG_HEAP_END) begin
        heap_end_q <= cfg_wdata_i;
      end
    end
  end

  // Latched free address
  logic [ADDR_W-1:0] addr_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      addr_q <= page_address_i;
    end
  end

  // Free checks
  logic [WW-1:0]   off;
  logic [WW-1:0]   off_pg;
  logic            free_bad;
  assign off    = {1'b0, addr_q} - base_q;
  assign off_pg = off >> PAGE_LOG;
  assign free_bad = (addr_q[PAGE_LOG-1:0] != '0) ||
                    (addr_q < heap_start_q) ||
                    (addr_q >= heap_end_q) ||
                    ({1'b0, addr_q} < base_q) ||
                    (off_pg >= PAGES_W);

  // Init page count, clamped to the table size
  logic [WW-1:0]   span_pg;
  logic [IDXW-1:0] init_cnt;
  assign span_pg = ({1'b0, heap_end_q} - base_q) >> PAGE_LOG;
  always_comb begin
    if (base_q > {1'b0, heap_end_q}) begin
      init_cnt = '0;
    end else if (span_pg >= PAGES_W) begin
      init_cnt = NULL_IDX;
    end else begin
      init_cnt = span_pg[IDXW-1:0];
    end
  end

  // Head, sweep counter and page count
  logic [IDXW-1:0] head_q, head_d;
  logic [IDXW-1:0] cnt_q, cnt_d;
  logic [IDXW-1:0] count_q, count_d;
  logic [IDXW-1:0] rd_q;
  logic            head_null;

  assign head_null = (head_q >= NULL_IDX);

  // Table write port
  logic            mem_we;
  logic [MW-1:0]   mem_waddr;

  always_comb begin
    head_d    = head_q;
    cnt_d     = cnt_q;
    count_d   = count_q;
    mem_we    = 1'b0;
    mem_waddr = cnt_q[MW-1:0];
    if (cmd_i.alloc_fin && !head_null) begin
      head_d = rd_q;
    end
    if (cmd_i.free_fin && !free_bad) begin
      mem_we    = 1'b1;
      mem_waddr = off_pg[MW-1:0];
      head_d    = off_pg[IDXW-1:0];
    end
    if (cmd_i.init_setup) begin
      head_d  = NULL_IDX;
      cnt_d   = '0;
      count_d = init_cnt;
    end
    if (cmd_i.init_push) begin
      mem_we = 1'b1;
      head_d = cnt_q;
      cnt_d  = cnt_q + IDXW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= NULL_IDX;
      cnt_q   <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      count_q <= count_d;
    end
  end

  assign stat_o.init_last = (cnt_q == count_q);

  // Next-index table; each push links the new entry to the old head
  logic [IDXW-1:0] next_mem [MAX_PAGES];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      next_mem[mem_waddr] <= head_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rd_q <= next_mem[head_q[MW-1:0]];
    end
  end

  // Result registers
  logic [WW-1:0]       grant_sum;
  logic [ADDR_W-1:0]   granted_q;
  logic [STAT_W-1:0]   status_q;

  assign grant_sum = base_q + (WW'(head_q) << PAGE_LOG);

  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc_fin) begin
      granted_q <= head_null ? '0 : grant_sum[ADDR_W-1:0];
      status_q  <= head_null ? STAT_EMPTY : STAT_OK;
    end else if (cmd_i.free_fin) begin
      granted_q <= '0;
      status_q  <= free_bad ? STAT_REJECT : STAT_OK;
    end else if (cmd_i.res_ok) begin
      granted_q <= '0;
      status_q  <= STAT_OK;
    end
  end

  assign granted_address_o = granted_q;
  assign status_o          = status_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pfla_ctrl.sv =====
// Controller of the page free-list allocator: command sequencing and the
// result strobe. Uses pfla_pkg; drives pfla_dp through dp_cmd_t.
`default_nettype none

module pfla_ctrl
  import pfla_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  input  wire logic [CMD_W-1:0] command_i,
  input  wire dp_stat_t         stat_i,
  output dp_cmd_t               cmd_o,
  output logic                  busy,
  output logic                  result_valid_o
);

  state_e state_q, state_d;
  logic   done_q, done_d;
  cmd_e   cmd_in;

  assign cmd_in = cmd_e'(command_i);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (cmd_in)
            CMD_ALLOC: state_d = S_ALLOC;
            CMD_FREE:  state_d = S_FREE;
            CMD_INIT:  state_d = S_INIT_SETUP;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_ALLOC:      state_d = S_IDLE;
      S_FREE:       state_d = S_IDLE;
      S_INIT_SETUP: state_d = S_INIT_RUN;
      S_INIT_RUN: begin
        if (stat_i.init_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o  = '0;
    done_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          if (cmd_in == CMD_NONE) begin
            cmd_o.res_ok = 1'b1;
            done_d       = 1'b1;
          end
        end
      end
      S_ALLOC: begin
        cmd_o.alloc_fin = 1'b1;
        done_d          = 1'b1;
      end
      S_FREE: begin
        cmd_o.free_fin = 1'b1;
        done_d         = 1'b1;
      end
      S_INIT_SETUP: begin
        cmd_o.init_setup = 1'b1;
      end
      S_INIT_RUN: begin
        if (stat_i.init_last) begin
          cmd_o.res_ok = 1'b1;
          done_d       = 1'b1;
        end else begin
          cmd_o.init_push = 1'b1;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = done_q;

endmodule

`default_nettype wire

// ===== hw/rtl/page_free_list_allocator.sv =====
// Page free-list allocator top level: LIFO list of fixed-size pages kept as a
// next-index table plus a head register. Alloc and free pass from acceptance
// through their own state, where the results load, to the result strobe; a
// new command is taken only back in idle. Init empties the list, then makes one
// table write per page; an unused command is answered from idle. The result
// strobe lasts one cycle. Reset empties the list and clears heap_start/heap_end;
// the table is not cleared. Depends on pfla_pkg, pfla_ctrl, pfla_dp.
`default_nettype none

module page_free_list_allocator
  import pfla_pkg::*;
#(
  parameter int unsigned MAX_PAGES  = MAX_PAGES_DEF,
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [ADDR_W-1:0]    cfg_wdata_i,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [CMD_W-1:0]     command_i,
  input  wire logic [ADDR_W-1:0]    page_address_i,
  output logic                      result_valid_o,
  output logic [ADDR_W-1:0]         granted_address_o,
  output logic [STAT_W-1:0]         status_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Sequencer
  pfla_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .command_i      (command_i),
    .stat_i         (dp_stat),
    .cmd_o          (dp_cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  // List storage and checks
  pfla_dp #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .page_address_i    (page_address_i),
    .cmd_i             (dp_cmd),
    .stat_o            (dp_stat),
    .granted_address_o (granted_address_o),
    .status_o          (status_o)
  );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for page_free_list_allocator: directed and random command traffic
// checked transaction by transaction against a free-list scoreboard class.
// Depends on pfla_pkg and the page_free_list_allocator RTL.

module tb_top;
  import pfla_pkg::*;

  typedef longint unsigned u64_t;

  localparam int unsigned PAGES = MAX_PAGES_DEF;
  localparam u64_t PAGE_SZ = u64_t'(PAGE_BYTES_DEF);
  localparam logic [ADDR_W-1:0] PAGE_STEP = PAGE_BYTES_DEF;
  localparam int unsigned N_ITEMS = 1750;
  // no start gaps while this range of commands goes out
  localparam int unsigned QUIET_LO = 600;
  localparam int unsigned QUIET_HI = 900;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_e           st;
  } grant_t;

  // Free-list predictor plus the queue of grants still owed by the block
  class page_grant_checker;
    logic [ADDR_W-1:0] heap_start;
    logic [ADDR_W-1:0] heap_end;
    int unsigned       head;
    int unsigned       next_tbl[PAGES];
    grant_t            pending[$];
    int unsigned       errors;

    function new();
      heap_start = '0;
      heap_end   = '0;
      head       = PAGES;
      errors     = 0;
      foreach (next_tbl[i]) next_tbl[i] = 0;
    endfunction

    function void report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
      if (idx == CFG_HEAP_START) heap_start = val;
      else heap_end = val;
    endfunction

    // heap_start rounded up to a page; may reach 2^32
    function u64_t page_base();
      return ((u64_t'(heap_start) + PAGE_SZ - 1) / PAGE_SZ) * PAGE_SZ;
    endfunction

    // whole pages in the heap window, capped at the table size
    function u64_t page_count();
      u64_t base;
      u64_t cnt;
      base = page_base();
      cnt  = 0;
      if (base <= u64_t'(heap_end)) cnt = (u64_t'(heap_end) - base) / PAGE_SZ;
      if (cnt > PAGES) cnt = u64_t'(PAGES);
      return cnt;
    endfunction

    function logic [ADDR_W-1:0] page_addr(int unsigned slot);
      u64_t a;
      a = page_base() + u64_t'(slot) * PAGE_SZ;
      return a[ADDR_W-1:0];
    endfunction

    function void push(int unsigned slot);
      next_tbl[slot] = head;
      head = slot;
    endfunction

    function grant_t predict_grant(cmd_e cmd, logic [ADDR_W-1:0] addr);
      grant_t g;
      u64_t   base;
      u64_t   a;
      u64_t   slot;
      u64_t   cnt;
      g.addr = '0;
      g.st   = STAT_OK;
      base   = page_base();
      a      = u64_t'(addr);
      case (cmd)
        CMD_ALLOC: begin
          if (head >= PAGES) begin
            g.st = STAT_EMPTY;
          end else begin
            g.addr = page_addr(head);
            head   = next_tbl[head];
          end
        end
        CMD_FREE: begin
          if ((a % PAGE_SZ) != 0 || addr < heap_start || addr >= heap_end || a < base) begin
            g.st = STAT_REJECT;
          end else begin
            slot = (a - base) / PAGE_SZ;
            if (slot >= PAGES) g.st = STAT_REJECT;
            else push(slot[31:0]);
          end
        end
        CMD_INIT: begin
          head = PAGES;
          cnt  = page_count();
          for (int unsigned i = 0; i < cnt; i++) push(i);
        end
        default: ;
      endcase
      return g;
    endfunction

    function grant_t note_command(cmd_e cmd, logic [ADDR_W-1:0] addr);
      grant_t g;
      g = predict_grant(cmd, addr);
      pending.push_back(g);
      return g;
    endfunction

    function void check_grant(logic [ADDR_W-1:0] addr, logic [STAT_W-1:0] st);
      grant_t g;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result addr %h status %0d", addr, st));
      end else begin
        g = pending.pop_front();
        if (addr !== g.addr)
          report($sformatf("granted_address got %h want %h", addr, g.addr));
        if (st !== g.st)
          report($sformatf("status got %0d want %0d", st, g.st));
      end
    endfunction
  endclass

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i      = CFG_HEAP_START;
  logic [ADDR_W-1:0]    cfg_wdata_i    = '0;
  logic                 start          = 1'b0;
  logic [CMD_W-1:0]     command_i      = CMD_NONE;
  logic [ADDR_W-1:0]    page_address_i = '0;
  logic                 busy;
  logic                 result_valid_o;
  logic [ADDR_W-1:0]    granted_address_o;
  logic [STAT_W-1:0]    status_o;

  page_grant_checker    sb;
  logic [ADDR_W-1:0]    held_pages[$];
  int unsigned          n_sent = 0;

  page_free_list_allocator u_top (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .start,
    .busy,
    .command_i,
    .page_address_i,
    .result_valid_o,
    .granted_address_o,
    .status_o
  );

  always #5 clk_i = ~clk_i;

  // Result monitor: each strobe is one transaction
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_grant(granted_address_o, status_o);
  end

  // Random start gaps outside the quiet window
  task automatic pause_random();
    if ((n_sent < QUIET_LO || n_sent >= QUIET_HI) && $urandom_range(0, 99) < 10) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
  endtask

  // Drive one command and wait until it is taken
  task automatic issue(cmd_e cmd, logic [ADDR_W-1:0] addr);
    grant_t g;
    pause_random();
    @(negedge clk_i);
    start          <= 1'b1;
    command_i      <= cmd;
    page_address_i <= addr;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    g = sb.note_command(cmd, addr);
    n_sent++;
    if (cmd == CMD_INIT) held_pages.delete();
    else if (cmd == CMD_ALLOC && g.st == STAT_OK) held_pages.push_back(g.addr);
  endtask

  // Drain all owed results before touching the registers
  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.pending.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_heap(logic [ADDR_W-1:0] hs, logic [ADDR_W-1:0] he);
    settle();
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_HEAP_START, hs);
      write_reg(CFG_HEAP_END, he);
    end else begin
      write_reg(CFG_HEAP_END, he);
      write_reg(CFG_HEAP_START, hs);
    end
  endtask

  // Free addresses that should mostly be rejected
  function automatic logic [ADDR_W-1:0] odd_address();
    logic [ADDR_W-1:0] a;
    u64_t              cnt;
    cnt = sb.page_count();
    case ($urandom_range(0, 4))
      0: a = $urandom;
      1: a = sb.page_addr($urandom_range(0, PAGES - 1)) | $urandom_range(1, PAGE_BYTES_DEF - 1);
      2: a = sb.page_addr(0) - PAGE_STEP;
      3: a = sb.page_addr(cnt[31:0]);
      default: a = sb.page_addr(PAGES + $urandom_range(0, 15));
    endcase
    return a;
  endfunction

  // Held page, or any page in the window (double frees allowed); odd address if the window is empty
  function automatic logic [ADDR_W-1:0] good_address();
    u64_t span;
    int   pick;
    logic [ADDR_W-1:0] a;
    span = sb.page_count();
    if (held_pages.size() != 0 && $urandom_range(0, 3) != 0) begin
      pick = $urandom_range(0, held_pages.size() - 1);
      a = held_pages[pick];
      if ($urandom_range(0, 19) != 0) held_pages.delete(pick);
    end else if (span != 0) begin
      a = sb.page_addr($urandom_range(0, span[31:0] - 1));
    end else begin
      a = odd_address();
    end
    return a;
  endfunction

  // One random phase: new heap window, usually an init, then mixed traffic
  task automatic random_phase();
    logic [ADDR_W-1:0] hs;
    logic [ADDR_W-1:0] he;
    u64_t              top;
    int unsigned       k;
    int unsigned       len;
    int unsigned       aw;
    int unsigned       r;
    case ($urandom_range(0, 9))
      0: begin
        hs = $urandom;
        he = $urandom;
      end
      1: begin
        hs = $urandom_range(32'hFFFF_FFFF, 32'hFFFF_0000);
        he = $urandom_range(0, 1) ? '1 : $urandom;
      end
      default: begin
        hs = $urandom_range(0, 32'hF000_0000);
        if ($urandom_range(0, 3) != 0) hs[11:0] = '0;
        k   = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 300) : $urandom_range(0, 40);
        top = ((u64_t'(hs) + PAGE_SZ - 1) / PAGE_SZ) * PAGE_SZ;
        top = top + u64_t'(k) * PAGE_SZ + u64_t'($urandom_range(0, PAGE_BYTES_DEF - 1));
        he  = top[ADDR_W-1:0];
      end
    endcase
    set_heap(hs, he);
    held_pages.delete();
    // skipping the init keeps the old list under the new window
    if ($urandom_range(0, 99) >= 15) issue(CMD_INIT, $urandom);
    len = $urandom_range(50, 110);
    aw  = $urandom_range(25, 70);
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < aw) issue(CMD_ALLOC, $urandom);
      else if (r < 92) issue(CMD_FREE, good_address());
      else if (r < 97) issue(CMD_FREE, odd_address());
      else if (r < 99) issue(CMD_NONE, $urandom);
      else issue(CMD_INIT, $urandom);
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset window is empty: nothing to allocate, every free rejected
    issue(CMD_ALLOC, '0);
    issue(CMD_FREE, '0);
    issue(CMD_INIT, '0);
    issue(CMD_NONE, '1);
    issue(CMD_ALLOC, '1);

    // unaligned start, window larger than the table
    set_heap(32'h0000_1001, 32'h0012_E005);
    issue(CMD_INIT, '0);
    issue(CMD_ALLOC, '0);
    issue(CMD_FREE, 32'h0010_1000);
    issue(CMD_FREE, 32'h0000_2001);  // misaligned
    issue(CMD_FREE, 32'h0000_1000);  // below heap_start
    issue(CMD_FREE, 32'h0010_2000);  // first page past the table
    issue(CMD_FREE, 32'h0012_E000);  // in window, past the table
    issue(CMD_FREE, 32'hFFFF_F000);  // above heap_end
    issue(CMD_FREE, 32'h0000_2000);  // double free
    issue(CMD_ALLOC, '0);
    issue(CMD_ALLOC, '0);

    // rounding heap_start up overflows
    set_heap('1, '1);
    issue(CMD_INIT, '0);
    issue(CMD_ALLOC, '0);
    issue(CMD_FREE, 32'hFFFF_F000);

    // full address space, then move the base under a live list
    set_heap('0, '1);
    issue(CMD_INIT, '0);
    issue(CMD_ALLOC, '0);
    issue(CMD_FREE, '0);
    settle();
    write_reg(CFG_HEAP_START, 32'hFFFF_F000);
    issue(CMD_ALLOC, '0);
    issue(CMD_ALLOC, '0);
    issue(CMD_FREE, 32'hFFFF_F000);

    while (n_sent < N_ITEMS) random_phase();

    // drain, then keep watching for stray strobes
    @(negedge clk_i);
    start <= 1'b0;
    for (int i = 0; i < 2000 && sb.pending.size() != 0; i++) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending.size()));
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== page_free_list_allocator.f =====
hw/rtl/pfla_pkg.sv
hw/rtl/pfla_dp.sv
hw/rtl/pfla_ctrl.sv
hw/rtl/page_free_list_allocator.sv
tb/tb_top.sv
